[sv/sru_pkg.sv]
// ----------------------------------------------------------------------------
// sru_pkg: shared types and constants of the SysEx RLE unpacker
// Item and result structs, status codes, length limits and result queue sizes.
// ----------------------------------------------------------------------------
package sru_pkg;

  // Width of the decoded byte counter
  localparam int unsigned LENGTH_BITS = 16;

  // Compare width: wide enough for capacity, the counter and one carry bit
  localparam int unsigned CMP_W = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

  // Largest count the counter can hold, at compare width
  localparam logic [CMP_W-1:0] LEN_MAX = {{(CMP_W - LENGTH_BITS){1'b0}},
                                          {LENGTH_BITS{1'b1}}};

  localparam logic [15:0] CAP_RESET = 16'hFFFF;

  // Header decode thresholds
  localparam logic [7:0] HDR_RUN_BASE  = 8'd64;  // at or above: run header
  localparam logic [7:0] HDR_BAD_LO    = 8'd60;  // 60..63 are reserved
  localparam logic [7:0] HDR_SIZE3_LO  = 8'd4;
  localparam logic [7:0] HDR_SIZE4_LO  = 8'd12;
  localparam logic [7:0] HDR_SIZE5_LO  = 8'd28;
  localparam logic [6:0] RUN_LEN_EXT   = 7'd31;  // length field that needs an ext byte

  // Result queue
  localparam int unsigned RES_FIFO_DEPTH = 4;
  localparam int unsigned RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
  localparam int unsigned RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_BAD_HEADER = 3'd1,
    STAT_TRUNC_GRP  = 3'd2,
    STAT_OVF_GRP    = 3'd3,
    STAT_TRUNC_RUN  = 3'd4,
    STAT_OVF_RUN    = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [8:0]  repeat_res;
    logic        end_of_message;
    status_e     status;
    logic [15:0] decoded_length;
  } res_item_t;

  // Up to two results written into the queue in one cycle, in order
  typedef struct packed {
    logic [1:0] cnt;
    res_item_t  first;
    res_item_t  second;
  } res_push_t;

endpackage

[sv/sysex_rle_unpacker_core.sv]
// ----------------------------------------------------------------------------
// sysex_rle_unpacker_core: 7-bit-safe run-length SysEx decoder
// Turns packed message bytes into (value, repeat) results plus a closing
// status item per message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one packed byte
//   per transfer, with a last flag on the final byte of a message.
//   Output channel (out_valid_o / out_ready_i / out_data_o) gives one result
//   per transfer: a data result (value and repeat count) or the closing item
//   of a message (end_of_message set, status, decoded length).
//   cfg_we_i / cfg_wdata_i write the capacity limit; write it between messages.
// Timing:
//   A byte is held and decoded in the input register; when that register
//   advances, its results are written into a four-entry result queue, and its
//   first result is offered from the queue from then on.
//   One byte per cycle is sustained while each byte makes at most one result
//   and the receiver takes every result; a final byte that also completes
//   data makes two results and takes two output transfers. The queue level
//   sets the rate: the register drains only while at least two entries are free.
// Reset: decoder state clears to "expecting header", the queue empties and
//   capacity returns to 65535. When the receiver stalls, the queue fills and
//   in_ready_o drops; nothing is lost or reordered.
// ----------------------------------------------------------------------------
module sysex_rle_unpacker_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sru_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sru_pkg::res_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);
  import sru_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_GROUP  = 2'd1,
    PH_EXT    = 2'd2,
    PH_VALUE  = 2'd3
  } phase_e;

  // Input register stage
  logic      v_q;
  in_item_t  item_q;
  logic      advance;

  // Decoder state
  phase_e                 phase_q, phase_d;
  logic [2:0]             group_left_q, group_left_d;
  logic [2:0]             group_index_q, group_index_d;
  logic [4:0]             high_mask_q, high_mask_d;
  logic                   run_high_q, run_high_d;
  logic [8:0]             run_len_q, run_len_d;
  logic [LENGTH_BITS-1:0] produced_q, produced_d;
  status_e                err_q, err_d;
  logic                   ovf_q, ovf_d;
  logic [15:0]            cap_q;

  logic [RES_CNT_W-1:0]   level;
  res_push_t              push_d;

  // The queue must have room for a data result and a closing item
  assign advance    = v_q && (level <= RES_CNT_W'(RES_FIFO_DEPTH - 2));
  assign in_ready_o = !v_q || advance;

  // --------------------------------------------------------------------------
  // Decode of the byte in the input register
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0] limit;
  logic [CMP_W-1:0] cap_ext;
  logic [7:0]       b;
  logic [7:0]       f;
  logic [2:0]       grp_size;
  logic [7:0]       grp_off;
  logic [4:0]       mask_sh;
  logic             emit;
  res_item_t        data_res;
  res_item_t        close_res;

  assign cap_ext = CMP_W'(cap_q);
  assign limit   = (cap_ext < LEN_MAX) ? cap_ext : LEN_MAX;
  assign b       = item_q.in_byte;
  assign f       = b - HDR_RUN_BASE;
  assign mask_sh = high_mask_q >> group_index_q;

  always_comb begin
    priority if (b < HDR_SIZE3_LO) begin
      grp_size = 3'd2; grp_off = 8'd0;
    end else if (b < HDR_SIZE4_LO) begin
      grp_size = 3'd3; grp_off = HDR_SIZE3_LO;
    end else if (b < HDR_SIZE5_LO) begin
      grp_size = 3'd4; grp_off = HDR_SIZE4_LO;
    end else begin
      grp_size = 3'd5; grp_off = HDR_SIZE5_LO;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    group_left_d  = group_left_q;
    group_index_d = group_index_q;
    high_mask_d   = high_mask_q;
    run_high_d    = run_high_q;
    run_len_d     = run_len_q;
    produced_d    = produced_q;
    err_d         = err_q;
    ovf_d         = ovf_q;
    emit          = 1'b0;
    data_res      = '0;
    close_res     = '0;
    push_d        = '0;

    // once an error is latched, only the final byte matters
    if (err_q == STAT_OK) begin
      unique case (phase_q)
        PH_HEADER: begin
          // a header on the final byte is dropped
          if (!item_q.last) begin
            if (b < HDR_RUN_BASE) begin
              if (b >= HDR_BAD_LO) begin
                err_d = STAT_BAD_HEADER;
              end else begin
                group_left_d  = grp_size;
                group_index_d = '0;
                high_mask_d   = 5'(b - grp_off);
                ovf_d         = (CMP_W'(produced_q) + CMP_W'(grp_size)) > limit;
                phase_d       = PH_GROUP;
              end
            end else begin
              run_high_d = f[0];
              run_len_d  = 9'(f[7:1]);
              phase_d    = (f[7:1] == RUN_LEN_EXT) ? PH_EXT : PH_VALUE;
            end
          end
        end
        PH_GROUP: begin
          if (item_q.last && group_left_q > 3'd1) begin
            err_d = STAT_TRUNC_GRP;
          end else begin
            if (!ovf_q) begin
              emit                = 1'b1;
              data_res.out_byte   = {mask_sh[0], b[6:0]};
              data_res.repeat_res = 9'd1;
              produced_d          = produced_q + LENGTH_BITS'(1);
            end
            group_index_d = group_index_q + 3'd1;
            group_left_d  = group_left_q - 3'd1;
            if (group_left_q == 3'd1) begin
              if (ovf_q) begin
                err_d = STAT_OVF_GRP;
              end
              ovf_d   = 1'b0;
              phase_d = PH_HEADER;
            end
          end
        end
        PH_EXT: begin
          run_len_d = 9'(RUN_LEN_EXT) + 9'(b);
          if (item_q.last) begin
            err_d = STAT_TRUNC_RUN;
          end else begin
            phase_d = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if ((CMP_W'(produced_q) + CMP_W'(run_len_q)) > limit) begin
            err_d = STAT_OVF_RUN;
          end else if (run_len_q != 9'd0) begin
            emit                = 1'b1;
            data_res.out_byte   = {b[7] ^ run_high_q, b[6:0]};
            data_res.repeat_res = run_len_q;
            produced_d          = produced_q + LENGTH_BITS'(run_len_q);
          end
          phase_d = PH_HEADER;
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
    end

    // closing item, then back to the start of a message
    if (item_q.last) begin
      close_res.end_of_message = 1'b1;
      close_res.status         = err_d;
      close_res.decoded_length = (err_d == STAT_OK) ? 16'(produced_d) : 16'd0;
      phase_d       = PH_HEADER;
      group_left_d  = '0;
      group_index_d = '0;
      high_mask_d   = '0;
      run_high_d    = 1'b0;
      run_len_d     = '0;
      produced_d    = '0;
      err_d         = STAT_OK;
      ovf_d         = 1'b0;
    end

    if (advance) begin
      if (emit && item_q.last) begin
        push_d.cnt    = 2'd2;
        push_d.first  = data_res;
        push_d.second = close_res;
      end else if (emit) begin
        push_d.cnt   = 2'd1;
        push_d.first = data_res;
      end else if (item_q.last) begin
        push_d.cnt   = 2'd1;
        push_d.first = close_res;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q           <= 1'b0;
      phase_q       <= PH_HEADER;
      group_left_q  <= '0;
      group_index_q <= '0;
      high_mask_q   <= '0;
      run_high_q    <= 1'b0;
      run_len_q     <= '0;
      produced_q    <= '0;
      err_q         <= STAT_OK;
      ovf_q         <= 1'b0;
      cap_q         <= CAP_RESET;
    end else begin
      if (in_ready_o) begin
        v_q <= in_valid_i;
      end
      if (advance) begin
        phase_q       <= phase_d;
        group_left_q  <= group_left_d;
        group_index_q <= group_index_d;
        high_mask_q   <= high_mask_d;
        run_high_q    <= run_high_d;
        run_len_q     <= run_len_d;
        produced_q    <= produced_d;
        err_q         <= err_d;
        ovf_q         <= ovf_d;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // input payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  sru_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_d),
    .level_o     (level),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.last) |=>
      (phase_q == PH_HEADER && produced_q == '0 && err_q == STAT_OK && !ovf_q))
    else $error("message state not cleared after closing item");

  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && err_q != STAT_OK) |->
      (push_d.cnt == 2'd0 || (push_d.cnt == 2'd1 && push_d.first.end_of_message)))
    else $error("data emitted after an error");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && err_q != STAT_OK && !item_q.last) |=> (err_q == $past(err_q)))
    else $error("latched error changed inside a message");

  a_group_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_GROUP) |-> (group_left_q != 3'd0))
    else $error("group phase with no bytes left");
`endif

endmodule

[sv/sru_res_fifo.sv]
// ----------------------------------------------------------------------------
// sru_res_fifo: result queue of the SysEx RLE unpacker
// Small register queue that takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module sru_res_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sru_pkg::res_push_t            push_i,
  output logic [sru_pkg::RES_CNT_W-1:0] level_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sru_pkg::res_item_t            out_data_o
);
  import sru_pkg::*;

  res_item_t              mem_q [RES_FIFO_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [RES_CNT_W-1:0]   cnt_q;
  logic                   pop;
  logic [RES_PTR_W-1:0]   wr_ptr_nxt;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign level_o     = cnt_q;
  assign wr_ptr_nxt  = wr_ptr_q + RES_PTR_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_i.cnt);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
      end
      cnt_q <= cnt_q + RES_CNT_W'(push_i.cnt) - RES_CNT_W'(pop);
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.second;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (RES_CNT_W + 1)'(cnt_q) + (RES_CNT_W + 1)'(push_i.cnt)
      <= (RES_CNT_W + 1)'(RES_FIFO_DEPTH))
    else $error("result queue written past its depth");

  a_push_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt == 2'd2) |-> push_i.second.end_of_message)
    else $error("second result of a cycle must close the message");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RES_CNT_W'(RES_FIFO_DEPTH))
    else $error("result queue level above its depth");
`endif

endmodule
